// ----- src/rag_pkg.sv -----
// ----------------------------------------------------------------------------
// rag_pkg: shared types, constants and microcode for the deadlock detector
// Holds the command codes, the sequencer step and control word types, and
// the read-only program that steps the graph datapath.
// ----------------------------------------------------------------------------
package rag_pkg;

    localparam int MAX_NODES        = 8;
    localparam int NODE_W           = 3;
    localparam int COUNT_W          = 4;
    localparam int MIN_CYCLE_DEPTH  = 3;
    localparam int NODE_COUNT_RESET = 5;

    typedef logic [NODE_W-1:0]    node_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [MAX_NODES-1:0] row_t;

    typedef enum logic [1:0] {
        CMD_REQUEST = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_DETECT  = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQUEST,
        S_RELEASE,
        S_DETECT,
        S_WALK_INIT,
        S_WALK_STEP,
        S_NEXT_START,
        S_EMIT
    } step_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_REQUEST,
        OP_RELEASE,
        OP_DETECT_INIT,
        OP_WALK_INIT,
        OP_WALK_STEP,
        OP_NEXT_START,
        OP_EMIT
    } op_t;

    // hold keeps the step; otherwise jump; otherwise fall through
    typedef enum logic [1:0] {
        HC_NEVER,
        HC_NO_BEAT,
        HC_WALKING,
        HC_OUT_FULL
    } hold_cond_t;

    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_DISPATCH,
        JC_START_DONE,
        JC_FOUND
    } jump_cond_t;

    typedef struct packed {
        op_t        op;
        hold_cond_t hold;
        jump_cond_t jump;
        step_t      target;
    } uword_t;

    function automatic uword_t ucode(input step_t s);
        uword_t w;
        case (s)
            S_IDLE:       w = '{OP_IDLE,        HC_NO_BEAT,  JC_DISPATCH,   S_IDLE};
            S_REQUEST:    w = '{OP_REQUEST,     HC_NEVER,    JC_ALWAYS,     S_EMIT};
            S_RELEASE:    w = '{OP_RELEASE,     HC_NEVER,    JC_ALWAYS,     S_EMIT};
            S_DETECT:     w = '{OP_DETECT_INIT, HC_NEVER,    JC_NEVER,      S_IDLE};
            S_WALK_INIT:  w = '{OP_WALK_INIT,   HC_NEVER,    JC_START_DONE, S_EMIT};
            S_WALK_STEP:  w = '{OP_WALK_STEP,   HC_WALKING,  JC_FOUND,      S_EMIT};
            S_NEXT_START: w = '{OP_NEXT_START,  HC_NEVER,    JC_ALWAYS,     S_WALK_INIT};
            S_EMIT:       w = '{OP_EMIT,        HC_OUT_FULL, JC_ALWAYS,     S_IDLE};
            default:      w = '{OP_IDLE,        HC_NEVER,    JC_ALWAYS,     S_IDLE};
        endcase
        return w;
    endfunction

    function automatic step_t dispatch(input cmd_t c);
        step_t s;
        case (c)
            CMD_REQUEST: s = S_REQUEST;
            CMD_RELEASE: s = S_RELEASE;
            CMD_DETECT:  s = S_DETECT;
            default:     s = S_EMIT;
        endcase
        return s;
    endfunction

    function automatic row_t node_mask(input count_t n);
        row_t m;
        for (int k = 0; k < MAX_NODES; k++)
        begin
            m[k] = (count_t'(k) < n);
        end
        return m;
    endfunction

endpackage

// ----- src/rag_item_if.sv -----
// ----------------------------------------------------------------------------
// rag_item_if: command channel of the deadlock detector
// Carries one command beat: command code, process node and resource node.
// ----------------------------------------------------------------------------
interface rag_item_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           cmd;
    rag_pkg::node_t       process_node;
    rag_pkg::node_t       resource_node;

    modport source (output valid, output cmd, output process_node,
                    output resource_node, input ready);
    modport sink   (input valid, input cmd, input process_node,
                    input resource_node, output ready);
endinterface

// ----- src/rag_result_if.sv -----
// ----------------------------------------------------------------------------
// rag_result_if: result channel of the deadlock detector
// Carries one result beat: grant flag, deadlock flag and cycle start node.
// ----------------------------------------------------------------------------
interface rag_result_if;
    logic                 valid;
    logic                 ready;
    logic                 granted;
    logic                 deadlock;
    rag_pkg::node_t       cycle_start;

    modport source (output valid, output granted, output deadlock,
                    output cycle_start, input ready);
    modport sink   (input valid, input granted, input deadlock,
                    input cycle_start, output ready);
endinterface

// ----- src/rag_deadlock_detector.sv -----
// ----------------------------------------------------------------------------
// rag_deadlock_detector: resource allocation graph with cycle detection
// Keeps the graph as an 8x8 adjacency bit matrix, applies request and release
// beats, and runs a depth-first walk from each node in use on a detect beat.
// A microcoded sequencer steps one shared walk datapath.
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  item      sink       valid/ready    cmd, process_node, resource_node
//  result    source     valid/ready    granted, deadlock, cycle_start
//  cfg       sink       cfg_wr_en      cfg_wr_data (node_count)
//
//  Request and release pass their own step, then the output step, which
//  registers result valid; unused goes straight to the output step.
//  Detect walks from each start node, paced by the single row read per cycle.
//  A new item beat is taken in the idle step while a result still waits.
//  Reset clears the graph, the walk control and node_count to 5; no sweep.
//  A stalled result holds the sequencer in its output step.
// ----------------------------------------------------------------------------
module rag_deadlock_detector
(
    input  logic                  clk,
    input  logic                  rst_n,
    rag_item_if.sink              item,
    rag_result_if.source          result,
    input  logic                  cfg_wr_en,
    input  logic [3:0]            cfg_wr_data
);

    typedef rag_pkg::row_t   row_t;
    typedef rag_pkg::node_t  node_t;
    typedef rag_pkg::count_t count_t;

    localparam count_t MAX_COUNT = count_t'(rag_pkg::MAX_NODES);

    rag_pkg::step_t  step_reg, step_next;
    rag_pkg::uword_t uw;

    count_t     node_count_reg, node_count_next;
    row_t       adj_reg [rag_pkg::MAX_NODES];
    row_t       adj_next [rag_pkg::MAX_NODES];
    row_t       visited_reg, visited_next;
    node_t      stack_reg [rag_pkg::MAX_NODES];
    node_t      stack_next [rag_pkg::MAX_NODES];
    count_t     col_reg [rag_pkg::MAX_NODES];
    count_t     col_next [rag_pkg::MAX_NODES];
    count_t     sp_reg, sp_next;
    count_t     start_reg, start_next;

    rag_pkg::cmd_t cmd_reg, cmd_next;
    node_t      proc_reg, proc_next;
    node_t      res_reg, res_next;
    logic       granted_reg, granted_next;
    logic       deadlock_reg, deadlock_next;

    logic       out_valid_reg, out_valid_next;
    logic       out_granted_reg, out_granted_next;
    logic       out_deadlock_reg, out_deadlock_next;
    node_t      out_start_reg, out_start_next;

    count_t     n;
    row_t       mask;
    node_t      row_addr;
    row_t       row;
    row_t       row_eff;
    logic       grant;
    node_t      lvl;
    node_t      top;
    count_t     col;
    logic       col_live;
    logic       edge_hit;
    logic       found;
    logic       start_done;
    logic       in_beat;
    logic       out_full;
    logic       hold;
    logic       jump;

    assign n          = (node_count_reg > MAX_COUNT) ? MAX_COUNT : node_count_reg;
    assign mask       = rag_pkg::node_mask(n);
    assign uw         = rag_pkg::ucode(step_reg);
    assign in_beat    = item.valid && item.ready;
    assign out_full   = out_valid_reg && !result.ready;
    assign start_done = (start_reg >= n);

    assign lvl      = sp_reg[rag_pkg::NODE_W-1:0] - node_t'(1);
    assign top      = stack_reg[lvl];
    assign col      = col_reg[lvl];
    assign col_live = (sp_reg != '0) && (col < n);
    assign row_addr = (uw.op == rag_pkg::OP_WALK_STEP) ? top : res_reg;
    assign row      = adj_reg[row_addr];
    assign edge_hit = col_live && row[col[rag_pkg::NODE_W-1:0]];
    assign found    = edge_hit && (col == start_reg)
                      && ({1'b0, lvl} >= count_t'(rag_pkg::MIN_CYCLE_DEPTH));

    always_comb
    begin
        row_eff = row;
        if (proc_reg == res_reg)
        begin
            row_eff[res_reg] = 1'b1;
        end
    end
    assign grant = ((row_eff & mask) == '0);

    always_comb
    begin
        case (uw.hold)
            rag_pkg::HC_NO_BEAT:  hold = !in_beat;
            rag_pkg::HC_WALKING:  hold = (sp_reg != '0) && !found;
            rag_pkg::HC_OUT_FULL: hold = out_full;
            default:              hold = 1'b0;
        endcase
        case (uw.jump)
            rag_pkg::JC_ALWAYS:     jump = 1'b1;
            rag_pkg::JC_DISPATCH:   jump = 1'b1;
            rag_pkg::JC_START_DONE: jump = start_done;
            rag_pkg::JC_FOUND:      jump = found;
            default:                jump = 1'b0;
        endcase
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (jump && uw.jump == rag_pkg::JC_DISPATCH)
        begin
            step_next = rag_pkg::dispatch(rag_pkg::cmd_t'(item.cmd));
        end
        else if (jump)
        begin
            step_next = uw.target;
        end
        else
        begin
            step_next = rag_pkg::step_t'(step_reg + 3'd1);
        end
    end

    always_comb
    begin
        node_count_next   = cfg_wr_en ? cfg_wr_data : node_count_reg;
        adj_next          = adj_reg;
        visited_next      = visited_reg;
        stack_next        = stack_reg;
        col_next          = col_reg;
        sp_next           = sp_reg;
        start_next        = start_reg;
        cmd_next          = cmd_reg;
        proc_next         = proc_reg;
        res_next          = res_reg;
        granted_next      = granted_reg;
        deadlock_next     = deadlock_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_granted_next  = out_granted_reg;
        out_deadlock_next = out_deadlock_reg;
        out_start_next    = out_start_reg;

        case (uw.op)
            rag_pkg::OP_IDLE:
            begin
                if (in_beat)
                begin
                    cmd_next      = rag_pkg::cmd_t'(item.cmd);
                    proc_next     = item.process_node;
                    res_next      = item.resource_node;
                    granted_next  = 1'b0;
                    deadlock_next = 1'b0;
                    start_next    = '0;
                end
            end
            rag_pkg::OP_REQUEST:
            begin
                if (grant)
                begin
                    adj_next[proc_reg][res_reg] = 1'b0;
                    adj_next[res_reg][proc_reg] = 1'b1;
                    granted_next                = 1'b1;
                end
                else
                begin
                    adj_next[proc_reg][res_reg] = 1'b1;
                end
            end
            rag_pkg::OP_RELEASE:
            begin
                adj_next[res_reg][proc_reg] = 1'b0;
            end
            rag_pkg::OP_DETECT_INIT:
            begin
                start_next    = '0;
                deadlock_next = 1'b0;
            end
            rag_pkg::OP_WALK_INIT:
            begin
                if (!start_done)
                begin
                    visited_next                         = '0;
                    visited_next[start_reg[rag_pkg::NODE_W-1:0]] = 1'b1;
                    stack_next[0]                        = start_reg[rag_pkg::NODE_W-1:0];
                    col_next[0]                          = '0;
                    sp_next                              = count_t'(1);
                end
            end
            rag_pkg::OP_WALK_STEP:
            begin
                if (sp_reg != '0)
                begin
                    if (!col_live)
                    begin
                        sp_next = sp_reg - count_t'(1);
                    end
                    else
                    begin
                        col_next[lvl] = col + count_t'(1);
                        if (found)
                        begin
                            deadlock_next = 1'b1;
                        end
                        else if (edge_hit && !visited_reg[col[rag_pkg::NODE_W-1:0]]
                                 && sp_reg < MAX_COUNT)
                        begin
                            visited_next[col[rag_pkg::NODE_W-1:0]]  = 1'b1;
                            stack_next[sp_reg[rag_pkg::NODE_W-1:0]] = col[rag_pkg::NODE_W-1:0];
                            col_next[sp_reg[rag_pkg::NODE_W-1:0]]   = '0;
                            sp_next                                 = sp_reg + count_t'(1);
                        end
                    end
                end
            end
            rag_pkg::OP_NEXT_START:
            begin
                start_next = start_reg + count_t'(1);
            end
            rag_pkg::OP_EMIT:
            begin
                if (!out_full)
                begin
                    out_valid_next    = 1'b1;
                    out_granted_next  = granted_reg;
                    out_deadlock_next = deadlock_reg;
                    out_start_next    = deadlock_reg ? start_reg[rag_pkg::NODE_W-1:0] : '0;
                    sp_next           = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= rag_pkg::S_IDLE;
            node_count_reg <= count_t'(rag_pkg::NODE_COUNT_RESET);
            adj_reg        <= '{default: '0};
            visited_reg    <= '0;
            sp_reg         <= '0;
            start_reg      <= '0;
            cmd_reg        <= rag_pkg::CMD_REQUEST;
            granted_reg    <= 1'b0;
            deadlock_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            node_count_reg <= node_count_next;
            adj_reg        <= adj_next;
            visited_reg    <= visited_next;
            sp_reg         <= sp_next;
            start_reg      <= start_next;
            cmd_reg        <= cmd_next;
            granted_reg    <= granted_next;
            deadlock_reg   <= deadlock_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stack_reg        <= stack_next;
        col_reg          <= col_next;
        proc_reg         <= proc_next;
        res_reg          <= res_next;
        out_granted_reg  <= out_granted_next;
        out_deadlock_reg <= out_deadlock_next;
        out_start_reg    <= out_start_next;
    end

    assign item.ready         = (step_reg == rag_pkg::S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.granted     = out_granted_reg;
    assign result.deadlock    = out_deadlock_reg;
    assign result.cycle_start = out_start_reg;

`ifndef SYNTHESIS
    a_sp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= MAX_COUNT)
        else $error("walk stack pointer beyond node limit");

    a_start_visited: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == rag_pkg::S_WALK_STEP && sp_reg != '0)
        |-> visited_reg[start_reg[rag_pkg::NODE_W-1:0]])
        else $error("start node not marked during walk");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(step_reg == rag_pkg::S_EMIT))
        else $error("result raised outside the output step");

    a_deadlock_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == rag_pkg::S_EMIT && deadlock_reg) |-> cmd_reg == rag_pkg::CMD_DETECT)
        else $error("deadlock flagged for a non-detect command");

    a_grant_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == rag_pkg::S_EMIT && granted_reg) |-> cmd_reg == rag_pkg::CMD_REQUEST)
        else $error("grant flagged for a non-request command");
`endif

endmodule
